FILE: hw/rtl/lpmtc_pkg.sv
// ----------------------------------------------------------------------------
// lpmtc_pkg
// Shared types and constants of the prefix-match traffic counter.
// ----------------------------------------------------------------------------
package lpmtc_pkg;

  localparam logic [1:0] REQ_PACKET     = 2'd0;
  localparam logic [1:0] REQ_WR_PREFIX  = 2'd1;
  localparam logic [1:0] REQ_RD_PREFIX  = 2'd2;
  localparam logic [1:0] REQ_RD_PROTO   = 2'd3;

  localparam logic [1:0] SEL_BYTES_OUT  = 2'd0;
  localparam logic [1:0] SEL_PKTS_OUT   = 2'd1;
  localparam logic [1:0] SEL_BYTES_IN   = 2'd2;
  localparam logic [1:0] SEL_PKTS_IN    = 2'd3;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [5:0]  ADDR_BITS      = 6'd32;

  // prefix memory word: valid, length, base
  localparam int PFX_W  = 39;
  // counter memory word: pkts_in, bytes_in, pkts_out, bytes_out
  localparam int CNT_W  = 256;
  // ethertype memory word: valid, key, count
  localparam int PROT_W = 49;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] ethertype;
    logic        outgoing;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        header_ok;
    logic [15:0] pkt_len;
    logic [7:0]  entry_index;
    logic        entry_valid;
    logic [5:0]  prefix_len;
    logic [31:0] prefix_addr;
    logic [1:0]  counter_select;
  } req_t;

  typedef struct packed {
    logic        matched;
    logic [7:0]  match_index;
    logic        proto_dropped;
    logic        read_valid;
    logic [31:0] read_key;
    logic [5:0]  read_prefix_len;
    logic [63:0] read_value;
  } rsp_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= ADDR_BITS) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/lpmtc_ram.sv
// ----------------------------------------------------------------------------
// lpmtc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lpm_traffic_counter_unit.sv
// ----------------------------------------------------------------------------
// lpm_traffic_counter_unit
// Ethertype census and IPv4 longest-prefix traffic counters.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready as one in_data transaction:
// a packet, a prefix entry write, a prefix counter read or an ethertype
// entry read. Every request yields exactly one out_data transaction on
// out_valid/out_ready.
// One request is worked at a time. A packet scans the ethertype memory and,
// for IPv4 with a usable header, the prefix memory, plus a counter update
// of the longest matching prefix if one matched; these linear scans through
// the single read port of each memory set the rate.
// Writes pass ST_PWRITE, reads ST_RDA and ST_RDB, before ST_FIN loads the result register.
// After reset a clearing pass zeroes every entry of all memories; in_ready
// stays low meanwhile.
// A result waits in the output register while out_ready is low; the next
// request is already accepted and worked, and only its own result waits
// for the register to drain.
// ----------------------------------------------------------------------------
module lpm_traffic_counter_unit #(
  parameter int PREFIX_ENTRIES = 256,
  parameter int PROTO_ENTRIES  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpmtc_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpmtc_pkg::rsp_t   out_data
);

  localparam int PA_W = $clog2(PREFIX_ENTRIES);
  localparam int QA_W = $clog2(PROTO_ENTRIES);
  localparam int MAXE = (PREFIX_ENTRIES > PROTO_ENTRIES) ? PREFIX_ENTRIES
                                                         : PROTO_ENTRIES;
  localparam int SW   = $clog2(MAXE) + 1;
  localparam int IW   = (SW > 9) ? SW : 9;

  typedef enum logic [9:0] {
    ST_CLR    = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_PSWEEP = 10'b00_0000_0100,
    ST_PWRITE = 10'b00_0000_1000,
    ST_LSWEEP = 10'b00_0001_0000,
    ST_CRD    = 10'b00_0010_0000,
    ST_CUP    = 10'b00_0100_0000,
    ST_RDA    = 10'b00_1000_0000,
    ST_RDB    = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  lpmtc_pkg::req_t   req_r;
  lpmtc_pkg::rsp_t   res_r, res_nxt;
  lpmtc_pkg::rsp_t   out_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     sw_r, sw_nxt;
  logic [SW-1:0]     didx_r;
  logic              dv_r, dv_nxt;
  logic              hit_r, hit_nxt;
  logic [QA_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [31:0]       hit_cnt_r, hit_cnt_nxt;
  logic              free_r, free_nxt;
  logic [QA_W-1:0]   free_idx_r, free_idx_nxt;
  logic              best_r, best_nxt;
  logic [PA_W-1:0]   best_idx_r, best_idx_nxt;
  logic [5:0]        best_len_r, best_len_nxt;

  // memory ports
  logic                              pfx_we, cnt_we, prot_we;
  logic [PA_W-1:0]                   pfx_waddr, cnt_waddr, pfx_raddr, cnt_raddr;
  logic [QA_W-1:0]                   prot_waddr, prot_raddr;
  logic [lpmtc_pkg::PFX_W-1:0]       pfx_wdata, pfx_rdata;
  logic [lpmtc_pkg::CNT_W-1:0]       cnt_wdata, cnt_rdata;
  logic [lpmtc_pkg::PROT_W-1:0]      prot_wdata, prot_rdata;

  lpmtc_ram #(.WIDTH(lpmtc_pkg::PFX_W), .DEPTH(PREFIX_ENTRIES)) u_pfx_ram (
    .clk(clk), .we(pfx_we), .waddr(pfx_waddr), .wdata(pfx_wdata),
    .raddr(pfx_raddr), .rdata(pfx_rdata)
  );

  lpmtc_ram #(.WIDTH(lpmtc_pkg::CNT_W), .DEPTH(PREFIX_ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  lpmtc_ram #(.WIDTH(lpmtc_pkg::PROT_W), .DEPTH(PROTO_ENTRIES)) u_prot_ram (
    .clk(clk), .we(prot_we), .waddr(prot_waddr), .wdata(prot_wdata),
    .raddr(prot_raddr), .rdata(prot_rdata)
  );

  // request decode
  logic [IW-1:0]   idx_ext;
  logic            idx_pfx_ok, idx_prot_ok;
  logic            sw_pfx_ok, sw_prot_ok;
  logic [31:0]     lookup_addr;
  logic            is_ipv4;
  logic [5:0]      wr_len;

  assign idx_ext     = IW'(req_r.entry_index);
  assign idx_pfx_ok  = idx_ext < IW'(PREFIX_ENTRIES);
  assign idx_prot_ok = idx_ext < IW'(PROTO_ENTRIES);
  assign sw_pfx_ok   = sw_r < SW'(PREFIX_ENTRIES);
  assign sw_prot_ok  = sw_r < SW'(PROTO_ENTRIES);
  assign lookup_addr = req_r.outgoing ? req_r.dst_addr : req_r.src_addr;
  assign is_ipv4     = (req_r.ethertype == lpmtc_pkg::ETHERTYPE_IPV4) && req_r.header_ok;
  assign wr_len      = (req_r.prefix_len > lpmtc_pkg::ADDR_BITS) ? lpmtc_pkg::ADDR_BITS
                                                                 : req_r.prefix_len;

  // memory read words
  logic        pv;
  logic [5:0]  plen;
  logic [31:0] pbase, pmask;
  logic        qv;
  logic [15:0] qkey;
  logic [31:0] qcnt;
  logic [63:0] c_by_out, c_pk_out, c_by_in, c_pk_in;

  assign pv    = pfx_rdata[38];
  assign plen  = pfx_rdata[37:32];
  assign pbase = pfx_rdata[31:0];
  assign pmask = lpmtc_pkg::len_mask(plen);
  assign qv    = prot_rdata[48];
  assign qkey  = prot_rdata[47:32];
  assign qcnt  = prot_rdata[31:0];
  assign c_pk_in  = cnt_rdata[255:192];
  assign c_by_in  = cnt_rdata[191:128];
  assign c_pk_out = cnt_rdata[127:64];
  assign c_by_out = cnt_rdata[63:0];

  assign pfx_raddr  = (state_r == ST_LSWEEP) ? sw_r[PA_W-1:0] : idx_ext[PA_W-1:0];
  assign cnt_raddr  = (state_r == ST_CRD) ? best_idx_r : idx_ext[PA_W-1:0];
  assign prot_raddr = (state_r == ST_PSWEEP) ? sw_r[QA_W-1:0] : idx_ext[QA_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    sw_nxt        = sw_r;
    dv_nxt        = 1'b0;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_len_nxt  = best_len_r;
    pfx_we        = 1'b0;
    pfx_waddr     = idx_ext[PA_W-1:0];
    pfx_wdata     = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = idx_ext[PA_W-1:0];
    cnt_wdata     = '0;
    prot_we       = 1'b0;
    prot_waddr    = idx_ext[QA_W-1:0];
    prot_wdata    = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        pfx_we     = sw_pfx_ok;
        pfx_waddr  = sw_r[PA_W-1:0];
        cnt_we     = sw_pfx_ok;
        cnt_waddr  = sw_r[PA_W-1:0];
        prot_we    = sw_prot_ok;
        prot_waddr = sw_r[QA_W-1:0];
        sw_nxt     = sw_r + SW'(1);
        if (sw_r == SW'(MAXE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt  = '0;
          sw_nxt   = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          best_nxt = 1'b0;
          best_len_nxt = '0;
          unique case (in_data.req_type)
            lpmtc_pkg::REQ_PACKET:    state_nxt = ST_PSWEEP;
            lpmtc_pkg::REQ_WR_PREFIX: state_nxt = ST_PWRITE;
            lpmtc_pkg::REQ_RD_PREFIX: state_nxt = ST_RDA;
            lpmtc_pkg::REQ_RD_PROTO:  state_nxt = ST_RDA;
            default:                  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PSWEEP: begin
        if (sw_prot_ok) begin
          dv_nxt = 1'b1;
          sw_nxt = sw_r + SW'(1);
        end
        if (dv_r) begin
          if (qv && (qkey == req_r.ethertype) && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = didx_r[QA_W-1:0];
            hit_cnt_nxt = qcnt;
          end
          if (!qv && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = didx_r[QA_W-1:0];
          end
        end
        if (!sw_prot_ok && !dv_r) begin
          state_nxt = ST_PWRITE;
        end
      end
      ST_PWRITE: begin
        sw_nxt = '0;
        if (req_r.req_type == lpmtc_pkg::REQ_WR_PREFIX) begin
          pfx_we    = idx_pfx_ok;
          pfx_wdata = {req_r.entry_valid, wr_len,
                       req_r.prefix_addr & lpmtc_pkg::len_mask(wr_len)};
          cnt_we    = idx_pfx_ok;
          state_nxt = ST_FIN;
        end else begin
          priority if (hit_r) begin
            prot_we    = 1'b1;
            prot_waddr = hit_idx_r;
            prot_wdata = {1'b1, req_r.ethertype, hit_cnt_r + 32'd1};
          end else if (free_r) begin
            prot_we    = 1'b1;
            prot_waddr = free_idx_r;
            prot_wdata = {1'b1, req_r.ethertype, 32'd1};
          end else begin
            res_nxt.proto_dropped = 1'b1;
          end
          state_nxt = is_ipv4 ? ST_LSWEEP : ST_FIN;
        end
      end
      ST_LSWEEP: begin
        if (sw_pfx_ok) begin
          dv_nxt = 1'b1;
          sw_nxt = sw_r + SW'(1);
        end
        if (dv_r && pv && (((lookup_addr ^ pbase) & pmask) == 32'd0)
            && (!best_r || (plen > best_len_r))) begin
          best_nxt     = 1'b1;
          best_idx_nxt = didx_r[PA_W-1:0];
          best_len_nxt = plen;
        end
        if (!sw_pfx_ok && !dv_r) begin
          state_nxt = best_r ? ST_CRD : ST_FIN;
        end
      end
      ST_CRD: begin
        state_nxt = ST_CUP;
      end
      ST_CUP: begin
        cnt_we    = 1'b1;
        cnt_waddr = best_idx_r;
        if (req_r.outgoing) begin
          cnt_wdata = {c_pk_in, c_by_in, c_pk_out + 64'd1,
                       c_by_out + 64'(req_r.pkt_len)};
        end else begin
          cnt_wdata = {c_pk_in + 64'd1, c_by_in + 64'(req_r.pkt_len),
                       c_pk_out, c_by_out};
        end
        res_nxt.matched     = 1'b1;
        res_nxt.match_index = 8'(best_idx_r);
        state_nxt = ST_FIN;
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        if (req_r.req_type == lpmtc_pkg::REQ_RD_PREFIX) begin
          if (idx_pfx_ok) begin
            res_nxt.read_valid      = pv;
            res_nxt.read_key        = pbase;
            res_nxt.read_prefix_len = plen;
            unique case (req_r.counter_select)
              lpmtc_pkg::SEL_BYTES_OUT: res_nxt.read_value = c_by_out;
              lpmtc_pkg::SEL_PKTS_OUT:  res_nxt.read_value = c_pk_out;
              lpmtc_pkg::SEL_BYTES_IN:  res_nxt.read_value = c_by_in;
              lpmtc_pkg::SEL_PKTS_IN:   res_nxt.read_value = c_pk_in;
              default:                  res_nxt.read_value = c_pk_in;
            endcase
          end
        end else if (idx_prot_ok) begin
          res_nxt.read_valid = qv;
          res_nxt.read_key   = 32'(qkey);
          res_nxt.read_value = 64'(qcnt);
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      sw_r        <= '0;
      dv_r        <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      best_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sw_r        <= sw_nxt;
      dv_r        <= dv_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      best_r      <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if ((state_r == ST_FIN) && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
    res_r      <= res_nxt;
    didx_r     <= sw_r;
    hit_idx_r  <= hit_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    free_idx_r <= free_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_len_r <= best_len_nxt;
  end

  // a counted match only comes from a packet, never alongside read data
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.matched) |-> (out_data.read_valid == 1'b0))
    else $error("match result carries read data");

  // the prefix scan only looks at entries inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_LSWEEP) && dv_r) |-> (didx_r < SW'(PREFIX_ENTRIES)))
    else $error("prefix scan beyond table");

  // a new result is loaded only when the output register is free or draining
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result overwritten");

endmodule
